>>> src/ntre_pkg.sv
// Package for the NDEF text record extractor.
// Holds the shared constants, status codes, register indexes and beat types.
// No dependencies; every other file refers to it by scoped names.
package ntre_pkg;

  // Width of the byte position counter inside one buffer.
  localparam int POS_BITS = 16;

  // Configuration register width and the largest usable buffer length.
  localparam int CFG_W = 16;
  localparam logic [CFG_W:0] POS_CAP = (CFG_W + 1)'((1 << POS_BITS) - 1);

  // Width of the sums that compare an end position against a length.
  localparam int SUM_W = ((POS_BITS > CFG_W) ? POS_BITS : CFG_W) + 2;

  // Queue depths.
  localparam int IN_DEPTH  = 4;
  localparam int OUT_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [0:0] REG_BUFFER_LENGTH = 1'd0;
  localparam logic [0:0] REG_MAX_TEXT      = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] BUFFER_LENGTH_RST = 16'd48;
  localparam logic [CFG_W-1:0] MAX_TEXT_RST      = 16'd64;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TERM    = 3'd1;
  localparam logic [2:0] ST_BOUNDS  = 3'd2;
  localparam logic [2:0] ST_NOTWK   = 3'd3;
  localparam logic [2:0] ST_NOTTEXT = 3'd4;
  localparam logic [2:0] ST_UTF16   = 3'd5;
  localparam logic [2:0] ST_LANG    = 3'd6;
  localparam logic [2:0] ST_EMPTY   = 3'd7;

  // Byte values that the front end recognizes.
  localparam logic [7:0] TLV_NULL    = 8'h00;
  localparam logic [7:0] TLV_TERM    = 8'hFE;
  localparam logic [7:0] TLV_LONGLEN = 8'hFF;
  localparam logic [7:0] TLV_NDEF    = 8'h03;
  localparam logic [7:0] TYPE_TEXT   = 8'h54;
  localparam logic [2:0] TNF_WK      = 3'h1;

  // Classification of one tag byte, worked out before it enters the queue.
  typedef struct packed {
    logic is_null;
    logic is_term;
    logic is_long;
    logic is_ndef;
    logic is_text_type;
    logic is_wk;
  } byte_cls_t;

  // One input beat as it waits in the input queue.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    byte_cls_t  cls;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0]  text_byte;
    logic        text_valid;
    logic [15:0] text_index;
    logic        done;
    logic [2:0]  status;
  } result_t;

endpackage

>>> src/ndef_text_record_extractor.sv
// Top level of the NDEF text record extractor: configuration registers,
// input front end, parser and result queue. Depends on ntre_pkg,
// ntre_front, ntre_parser and ntre_out_queue.
// A byte is registered in the input queue and its result is registered
// in the result queue before it shows on the result ports.
// Throughput: one byte per cycle, set by the parser taking one queued byte
// per cycle whenever the result queue has room.
// Reset (asynchronous, active low): both queues empty, parser idle,
// buffer_length 48 and max_text 64.
module ndef_text_record_extractor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   data_byte_i,
  input  logic                         start_req_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   text_byte_o,
  output logic                         text_valid_o,
  output logic [15:0]                  text_index_o,
  output logic                         done_res_o,
  output logic [2:0]                   status_o,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [ntre_pkg::CFG_W-1:0]   cfg_wdata_i
);

  logic [ntre_pkg::CFG_W-1:0] buffer_length_q, buffer_length_d;
  logic [ntre_pkg::CFG_W-1:0] max_text_q, max_text_d;
  ntre_pkg::in_item_t         in_head;
  logic                       in_empty;
  logic                       in_pop;
  logic                       out_full;
  logic                       out_push;
  ntre_pkg::result_t          out_item;
  ntre_pkg::result_t          out_head;

  // Configuration register writes.
  always_comb begin
    buffer_length_d = buffer_length_q;
    max_text_d      = max_text_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ntre_pkg::REG_BUFFER_LENGTH: buffer_length_d = cfg_wdata_i;
        ntre_pkg::REG_MAX_TEXT:      max_text_d      = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_length_q <= ntre_pkg::BUFFER_LENGTH_RST;
      max_text_q      <= ntre_pkg::MAX_TEXT_RST;
    end else begin
      buffer_length_q <= buffer_length_d;
      max_text_q      <= max_text_d;
    end
  end

  // Byte classification and input queue.
  ntre_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .start_req_i (start_req_i),
    .pop_i       (in_pop),
    .empty_o     (in_empty),
    .head_o      (in_head)
  );

  // TLV and record parser.
  ntre_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .buffer_length_i (buffer_length_q),
    .max_text_i      (max_text_q),
    .in_empty_i      (in_empty),
    .in_item_i       (in_head),
    .in_pop_o        (in_pop),
    .out_full_i      (out_full),
    .out_push_o      (out_push),
    .out_item_o      (out_item)
  );

  // Result queue.
  ntre_out_queue u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .item_i (out_item),
    .full_o (out_full),
    .pop    (pop),
    .empty  (empty),
    .head_o (out_head)
  );

  assign text_byte_o  = out_head.text_byte;
  assign text_valid_o = out_head.text_valid;
  assign text_index_o = out_head.text_index;
  assign done_res_o   = out_head.done;
  assign status_o     = out_head.status;

endmodule

>>> src/ntre_front.sv
// Front end of the NDEF text record extractor: classifies each tag byte
// and holds it in a short input queue until the parser takes it.
// Depends on ntre_pkg.
module ntre_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte_i,
  input  logic                start_req_i,
  input  logic                pop_i,
  output logic                empty_o,
  output ntre_pkg::in_item_t  head_o
);

  localparam int DEPTH = ntre_pkg::IN_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  ntre_pkg::in_item_t  mem_q [DEPTH];
  ntre_pkg::in_item_t  item;
  logic [PW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [PW:0]         count_q, count_d;
  logic                do_push, do_pop;

  // Classify the incoming byte.
  always_comb begin
    item.data             = data_byte_i;
    item.start            = start_req_i;
    item.cls.is_null      = (data_byte_i == ntre_pkg::TLV_NULL);
    item.cls.is_term      = (data_byte_i == ntre_pkg::TLV_TERM);
    item.cls.is_long      = (data_byte_i == ntre_pkg::TLV_LONGLEN);
    item.cls.is_ndef      = (data_byte_i == ntre_pkg::TLV_NDEF);
    item.cls.is_text_type = (data_byte_i == ntre_pkg::TYPE_TEXT);
    item.cls.is_wk        = (data_byte_i[2:0] == ntre_pkg::TNF_WK);
  end

  // Queue pointers and fill level.
  assign full    = (count_q == (PW + 1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push && !full;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage for the waiting beats.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  assign head_o = mem_q[rd_ptr_q];

endmodule

>>> src/ntre_out_queue.sv
// Result queue of the NDEF text record extractor: decouples the parser
// from the consumer that pops result beats. Depends on ntre_pkg.
module ntre_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ntre_pkg::result_t  item_i,
  output logic               full_o,
  input  logic               pop,
  output logic               empty,
  output ntre_pkg::result_t  head_o
);

  localparam int DEPTH = ntre_pkg::OUT_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  ntre_pkg::result_t  mem_q [DEPTH];
  logic [PW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [PW:0]        count_q, count_d;
  logic               do_push, do_pop;

  // Pointers and fill level.
  assign full_o  = (count_q == (PW + 1)'(DEPTH));
  assign empty   = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o = mem_q[rd_ptr_q];

endmodule

>>> src/ntre_parser.sv
// Back end of the NDEF text record extractor: the TLV and record parser.
// Takes one classified byte per cycle while the result queue has room
// and produces at most one result beat. Depends on ntre_pkg.
module ntre_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ntre_pkg::CFG_W-1:0] buffer_length_i,
  input  logic [ntre_pkg::CFG_W-1:0] max_text_i,
  input  logic                     in_empty_i,
  input  ntre_pkg::in_item_t       in_item_i,
  output logic                     in_pop_o,
  input  logic                     out_full_i,
  output logic                     out_push_o,
  output ntre_pkg::result_t        out_item_o
);

  localparam int PB = ntre_pkg::POS_BITS;
  localparam int SW = ntre_pkg::SUM_W;

  // Parser phases.
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_TAG      = 4'd1;
  localparam logic [3:0] PH_LEN0     = 4'd2;
  localparam logic [3:0] PH_LENH     = 4'd3;
  localparam logic [3:0] PH_LENL     = 4'd4;
  localparam logic [3:0] PH_SKIP     = 4'd5;
  localparam logic [3:0] PH_HDR      = 4'd6;
  localparam logic [3:0] PH_TYPELEN  = 4'd7;
  localparam logic [3:0] PH_PLEN     = 4'd8;
  localparam logic [3:0] PH_IDLEN    = 4'd9;
  localparam logic [3:0] PH_TYPE     = 4'd10;
  localparam logic [3:0] PH_SKIPID   = 4'd11;
  localparam logic [3:0] PH_STATUS   = 4'd12;
  localparam logic [3:0] PH_SKIPLANG = 4'd13;
  localparam logic [3:0] PH_TEXT     = 4'd14;

  logic [3:0]    phase_q, phase_d;
  logic [PB-1:0] position_q, position_d;
  logic          tag_ndef_q, tag_ndef_d;
  logic [31:0]   field_accum_q, field_accum_d;
  logic [15:0]   skip_q, skip_d;
  logic [PB-1:0] msg_end_q, msg_end_d;
  logic          sr_q, sr_d;
  logic          il_q, il_d;
  logic          type_one_q, type_one_d;
  logic [7:0]    id_len_q, id_len_d;
  logic [31:0]   payload_q, payload_d;
  logic [15:0]   text_left_q, text_left_d;
  logic [15:0]   text_count_q, text_count_d;

  logic          consume;
  logic [7:0]    b;
  logic [3:0]    ph_cur;
  logic [PB-1:0] pos_cur;
  logic [PB-1:0] eff_len;
  logic [PB:0]   idx;
  logic          pos_out;
  logic          idx_at_len;
  logic          long_over;
  logic [15:0]   tlv_len;
  logic [SW-1:0] tlv_end;
  logic          idx_ge_end;
  logic          idx4_over;
  logic [33:0]   type_end;
  logic          type_over;
  logic [5:0]    lang;
  logic          lang_bad;
  logic [31:0]   text_avail;
  logic [15:0]   text_cut;
  logic [31:0]   acc_shift;
  logic          fin;
  logic [2:0]    fin_code;
  logic          len_known;
  logic          chk_type;

  // A beat moves only when the result queue has room for what it may cause.
  assign consume  = !in_empty_i && !out_full_i;
  assign in_pop_o = consume;
  assign b        = in_item_i.data;

  // A start byte restarts parsing at position zero.
  assign ph_cur  = in_item_i.start ? PH_TAG : phase_q;
  assign pos_cur = in_item_i.start ? '0 : position_q;

  // Effective buffer length, capped to what the position counter can hold.
  assign eff_len = ({1'b0, buffer_length_i} > ntre_pkg::POS_CAP) ?
                   ntre_pkg::POS_CAP[PB-1:0] : buffer_length_i[PB-1:0];

  // Bounds arithmetic against the buffer and the message end.
  assign idx        = {1'b0, pos_cur} + {{PB{1'b0}}, 1'b1};
  assign pos_out    = (pos_cur >= eff_len);
  assign idx_at_len = (idx >= {1'b0, eff_len});
  assign long_over  = (SW'(pos_cur) + SW'(3)) > SW'(eff_len);
  assign tlv_len    = (ph_cur == PH_LEN0) ? {8'h00, b} : {field_accum_q[7:0], b};
  assign tlv_end    = SW'(idx) + SW'(tlv_len);
  assign idx_ge_end = (idx >= {1'b0, msg_end_q});
  assign idx4_over  = (SW'(idx) + SW'(4)) > SW'(msg_end_q);
  assign type_end   = 34'(idx) + 34'(id_len_q) + 34'(payload_q);
  assign type_over  = (type_end > 34'(msg_end_q));
  assign acc_shift  = {field_accum_q[23:0], b};

  // Text length from the record status byte, cut to the configured maximum.
  assign lang       = b[5:0];
  assign lang_bad   = (33'(lang) + 33'd1) > 33'(payload_q);
  assign text_avail = payload_q - 32'(lang) - 32'd1;
  assign text_cut   = (text_avail > 32'(max_text_i)) ? max_text_i : text_avail[15:0];

  // Next-state and result logic.
  always_comb begin
    phase_d       = phase_q;
    position_d    = position_q;
    tag_ndef_d    = tag_ndef_q;
    field_accum_d = field_accum_q;
    skip_d        = skip_q;
    msg_end_d     = msg_end_q;
    sr_d          = sr_q;
    il_d          = il_q;
    type_one_d    = type_one_q;
    id_len_d      = id_len_q;
    payload_d     = payload_q;
    text_left_d   = text_left_q;
    text_count_d  = text_count_q;
    out_push_o    = 1'b0;
    out_item_o    = '0;
    fin           = 1'b0;
    fin_code      = ntre_pkg::ST_OK;
    len_known     = 1'b0;
    chk_type      = 1'b0;

    if (consume && ph_cur != PH_IDLE) begin
      phase_d    = ph_cur;
      position_d = pos_cur;
      if (pos_out) begin
        fin      = 1'b1;
        fin_code = ntre_pkg::ST_BOUNDS;
      end else begin
        position_d = idx[PB-1:0];
        unique case (ph_cur)
          PH_TAG: begin
            if (in_item_i.cls.is_term) begin
              fin      = 1'b1;
              fin_code = ntre_pkg::ST_TERM;
            end else if (idx_at_len) begin
              fin      = 1'b1;
              fin_code = ntre_pkg::ST_BOUNDS;
            end else if (!in_item_i.cls.is_null) begin
              tag_ndef_d = in_item_i.cls.is_ndef;
              phase_d    = PH_LEN0;
            end
          end
          PH_LEN0: begin
            if (in_item_i.cls.is_long) begin
              if (long_over) begin
                fin      = 1'b1;
                fin_code = ntre_pkg::ST_BOUNDS;
              end else begin
                phase_d = PH_LENH;
              end
            end else begin
              len_known = 1'b1;
            end
          end
          PH_LENH: begin
            field_accum_d = {24'h0, b};
            phase_d       = PH_LENL;
          end
          PH_LENL: begin
            len_known = 1'b1;
          end
          PH_SKIP: begin
            skip_d = skip_q - 16'd1;
            if (skip_q == 16'd1) begin
              phase_d = PH_TAG;
            end
          end
          PH_HDR: begin
            sr_d = b[4];
            il_d = b[3];
            if (!in_item_i.cls.is_wk) begin
              fin      = 1'b1;
              fin_code = ntre_pkg::ST_NOTWK;
            end else if (idx_ge_end) begin
              fin      = 1'b1;
              fin_code = ntre_pkg::ST_BOUNDS;
            end else begin
              phase_d = PH_TYPELEN;
            end
          end
          PH_TYPELEN: begin
            type_one_d    = (b == 8'h01);
            field_accum_d = '0;
            if (sr_q) begin
              skip_d = 16'd1;
              if (idx_ge_end) begin
                fin      = 1'b1;
                fin_code = ntre_pkg::ST_BOUNDS;
              end
            end else begin
              skip_d = 16'd4;
              if (idx4_over) begin
                fin      = 1'b1;
                fin_code = ntre_pkg::ST_BOUNDS;
              end
            end
            phase_d = PH_PLEN;
          end
          PH_PLEN: begin
            field_accum_d = acc_shift;
            skip_d        = skip_q - 16'd1;
            if (skip_q == 16'd1) begin
              payload_d = acc_shift;
              id_len_d  = '0;
              if (il_q) begin
                if (idx_ge_end) begin
                  fin      = 1'b1;
                  fin_code = ntre_pkg::ST_BOUNDS;
                end else begin
                  phase_d = PH_IDLEN;
                end
              end else begin
                chk_type = 1'b1;
              end
            end
          end
          PH_IDLEN: begin
            id_len_d = b;
            chk_type = 1'b1;
          end
          PH_TYPE: begin
            if (!in_item_i.cls.is_text_type) begin
              fin      = 1'b1;
              fin_code = ntre_pkg::ST_NOTTEXT;
            end else if (type_over) begin
              fin      = 1'b1;
              fin_code = ntre_pkg::ST_BOUNDS;
            end else if (payload_q == '0) begin
              fin      = 1'b1;
              fin_code = ntre_pkg::ST_EMPTY;
            end else if (id_len_q != '0) begin
              skip_d  = {8'h00, id_len_q};
              phase_d = PH_SKIPID;
            end else begin
              phase_d = PH_STATUS;
            end
          end
          PH_SKIPID: begin
            skip_d = skip_q - 16'd1;
            if (skip_q == 16'd1) begin
              phase_d = PH_STATUS;
            end
          end
          PH_STATUS: begin
            if (b[7]) begin
              fin      = 1'b1;
              fin_code = ntre_pkg::ST_UTF16;
            end else if (lang_bad) begin
              fin      = 1'b1;
              fin_code = ntre_pkg::ST_LANG;
            end else if (text_cut == '0) begin
              fin      = 1'b1;
              fin_code = ntre_pkg::ST_EMPTY;
            end else begin
              text_left_d  = text_cut;
              text_count_d = '0;
              if (lang != '0) begin
                skip_d  = {10'h000, lang};
                phase_d = PH_SKIPLANG;
              end else begin
                phase_d = PH_TEXT;
              end
            end
          end
          PH_SKIPLANG: begin
            skip_d = skip_q - 16'd1;
            if (skip_q == 16'd1) begin
              phase_d = PH_TEXT;
            end
          end
          PH_TEXT: begin
            out_push_o            = 1'b1;
            out_item_o.text_byte  = b;
            out_item_o.text_valid = 1'b1;
            out_item_o.text_index = text_count_q;
            text_count_d          = text_count_q + 16'd1;
            text_left_d           = text_left_q - 16'd1;
            if (text_left_q == 16'd1) begin
              out_item_o.done   = 1'b1;
              out_item_o.status = ntre_pkg::ST_OK;
              phase_d           = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase

        // TLV length now known: skip the TLV or enter the NDEF message.
        if (len_known) begin
          if (!tag_ndef_q) begin
            if (tlv_end >= SW'(eff_len)) begin
              fin      = 1'b1;
              fin_code = ntre_pkg::ST_BOUNDS;
            end else if (tlv_len == '0) begin
              phase_d = PH_TAG;
            end else begin
              skip_d  = tlv_len;
              phase_d = PH_SKIP;
            end
          end else if (tlv_end > SW'(eff_len) || tlv_len == '0) begin
            fin      = 1'b1;
            fin_code = ntre_pkg::ST_BOUNDS;
          end else begin
            msg_end_d = tlv_end[PB-1:0];
            phase_d   = PH_HDR;
          end
        end

        // Type length and room for the type byte are checked together.
        if (chk_type) begin
          if (!type_one_q) begin
            fin      = 1'b1;
            fin_code = ntre_pkg::ST_NOTTEXT;
          end else if (idx_ge_end) begin
            fin      = 1'b1;
            fin_code = ntre_pkg::ST_BOUNDS;
          end else begin
            phase_d = PH_TYPE;
          end
        end
      end

      // A failure or early end closes the buffer with a done beat.
      if (fin) begin
        phase_d           = PH_IDLE;
        out_push_o        = 1'b1;
        out_item_o        = '0;
        out_item_o.done   = 1'b1;
        out_item_o.status = fin_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      position_q    <= '0;
      tag_ndef_q    <= 1'b0;
      field_accum_q <= '0;
      skip_q        <= '0;
      msg_end_q     <= '0;
      sr_q          <= 1'b0;
      il_q          <= 1'b0;
      type_one_q    <= 1'b0;
      id_len_q      <= '0;
      payload_q     <= '0;
      text_left_q   <= '0;
      text_count_q  <= '0;
    end else begin
      phase_q       <= phase_d;
      position_q    <= position_d;
      tag_ndef_q    <= tag_ndef_d;
      field_accum_q <= field_accum_d;
      skip_q        <= skip_d;
      msg_end_q     <= msg_end_d;
      sr_q          <= sr_d;
      il_q          <= il_d;
      type_one_q    <= type_one_d;
      id_len_q      <= id_len_d;
      payload_q     <= payload_d;
      text_left_q   <= text_left_d;
      text_count_q  <= text_count_d;
    end
  end

  // The text phase always has at least one byte left to send.
  a_text_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_TEXT |-> text_left_q != '0)
    else $error("text phase entered with no text left");

  // Skip phases always have a nonzero count.
  a_skip_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP || phase_q == PH_SKIPID || phase_q == PH_SKIPLANG)
    |-> skip_q != '0)
    else $error("skip phase with zero count");

  // Every result beat is either a text byte or a done beat.
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> (out_item_o.text_valid || out_item_o.done))
    else $error("result beat carries neither text nor done");

  // A done beat leaves the parser idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o && out_item_o.done |=> phase_q == PH_IDLE)
    else $error("parser not idle after a done beat");

  // No result is produced unless the result queue had room.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result pushed into a full queue");

endmodule
